// ===== rtl/core/tsp_pkg.sv =====
// shared types and register codes for the token spam probability scorer
`default_nettype none

package tsp_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GOOD_BIAS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WORD_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEW_WORD_SCORE = 2'd2;

    // one token item
    typedef struct packed {
        logic [23:0] good_hits;
        logic [23:0] spam_hits;
        logic [15:0] occurrences;
        logic [23:0] good_messages;
        logic [23:0] spam_messages;
    } t_in;

    // one scored item
    typedef struct packed {
        logic [23:0] probability;
        logic [21:0] sort_key;
        logic [19:0] tie_break;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/core/token_spam_probability.sv =====
// token spam probability scorer: ratio dividers, combine divider, scaling
// throughput: one item per cycle while the output is not held, set by one quotient bit per divider stage
// a stalled output holds the whole pipeline; results are never dropped
// reset: synchronous active low, clears valid bits and loads register defaults
// (good_bias 2, min_word_count 5, new_word_score 6710886)
`default_nettype none

module token_spam_probability import tsp_pkg::*; #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_in                      i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output t_out                          o_data,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int F = FRAC_BITS;
    localparam int CW = (COUNT_BITS < 24) ? COUNT_BITS : 24;
    localparam int W1 = CW + 4;
    localparam int W2 = F + 1;
    localparam int LANES1 = 3;
    localparam logic [63:0] ONE_L = 64'd1 << F;
    localparam logic [F-1:0] PMIN = F'(ONE_L / 64'd1000000);
    localparam logic [F-1:0] PMAX = F'((ONE_L * 64'd999999) / 64'd1000000);
    localparam logic [F-1:0] PZERO = F'(ONE_L / 64'd10000000);
    localparam logic [F-1:0] HALF = F'(ONE_L >> 1);
    localparam int SH_DN = (F >= 24) ? F - 24 : 0;
    localparam int SH_UP = (F < 24) ? 24 - F : 0;

    typedef struct packed {
        logic [2:0]   zero;
        logic [2:0]   sat;
        logic         use_ratio;
        logic [4:0]   wdf;
        logic [F-1:0] p_new;
    } t_s1;

    typedef struct packed {
        logic         zero;
        logic         sat;
        logic         use_ratio;
        logic [4:0]   wdf;
        logic [F-1:0] p_new;
        logic [F-1:0] sr;
        logic [F-1:0] rg;
    } t_s2;

    // clamp a quotient by the ratio rule
    function automatic logic [F-1:0] clamp_ratio(input logic z, input logic s,
                                                 input logic [F-1:0] q);
        logic [F-1:0] r;
        if (z) begin
            r = PZERO;
        end else if (s) begin
            r = PMAX;
        end else if (q < PMIN) begin
            r = PMIN;
        end else if (q > PMAX) begin
            r = PMAX;
        end else begin
            r = q;
        end
        return r;
    endfunction

    logic       en;
    logic [3:0] r_good_bias;
    logic [7:0] r_min_wc;
    logic [23:0] r_new_score;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good_bias <= 4'd2;
            r_min_wc    <= 8'd5;
            r_new_score <= 24'd6710886;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GOOD_BIAS:      r_good_bias <= i_cfg_wdata[3:0];
                CFG_MIN_WORD_COUNT: r_min_wc <= i_cfg_wdata[7:0];
                CFG_NEW_WORD_SCORE: r_new_score <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // whole pipeline moves unless the output item is held
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // input stage with biased good count
    logic          r_a_vld;
    logic [CW-1:0] r_a_good, r_a_spam, r_a_gmsg, r_a_smsg;
    logic [15:0]   r_a_occ;
    logic [W1-1:0] r_a_biased;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_good   <= i_data.good_hits[CW-1:0];
            r_a_spam   <= i_data.spam_hits[CW-1:0];
            r_a_gmsg   <= i_data.good_messages[CW-1:0];
            r_a_smsg   <= i_data.spam_messages[CW-1:0];
            r_a_occ    <= i_data.occurrences;
            r_a_biased <= W1'(i_data.good_hits[CW-1:0]) * W1'(r_good_bias);
        end
    end

    // flags and operands for the ratio dividers
    t_s1              s1_in;
    logic [W1:0]      total;
    logic [31:0]      occ_div;
    logic [15:0]      occ3;
    logic [F+23:0]    nws_ext;
    logic [LANES1-1:0][W1-1:0] d1_num, d1_den;

    assign total   = {1'b0, r_a_biased} + (W1 + 1)'(r_a_spam);
    assign occ_div = 32'(r_a_occ) * 32'd43691;
    assign occ3    = {1'b0, occ_div[31:17]};
    assign nws_ext = (F + 24)'(r_new_score);

    assign d1_num[0] = r_a_biased;
    assign d1_den[0] = W1'(r_a_gmsg);
    assign d1_num[1] = W1'(r_a_spam);
    assign d1_den[1] = W1'(r_a_smsg);
    assign d1_num[2] = W1'(r_a_good);
    assign d1_den[2] = W1'(r_a_gmsg);

    always_comb begin
        for (int j = 0; j < LANES1; j++) begin
            s1_in.zero[j] = (d1_num[j] == '0);
            s1_in.sat[j]  = (d1_num[j] >= d1_den[j]);
        end
        s1_in.use_ratio = (total >= (W1 + 1)'(r_min_wc));
        s1_in.wdf       = (occ3 > 16'd20) ? 5'd20 : occ3[4:0];
        s1_in.p_new     = F'((nws_ext << SH_DN) >> SH_UP);
    end

    logic                      d1_vld;
    logic [LANES1-1:0][F-1:0]  d1_quo;
    logic [$bits(t_s1)-1:0]    d1_side;

    tsp_div_pipe #(
        .LANES (LANES1),
        .W     (W1),
        .Q     (F),
        .SW    ($bits(t_s1))
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_vld),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  (s1_in),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // clamp ratios, set up the combining division
    t_s1              s1_out;
    t_s2              s2_in;
    logic [F-1:0]     gr;
    logic [F-1:0]     sr;
    logic [W2-1:0]    sum;
    logic [0:0][W2-1:0] d2_num, d2_den;

    assign s1_out = t_s1'(d1_side);
    assign gr     = clamp_ratio(s1_out.zero[0], s1_out.sat[0], d1_quo[0]);
    assign sr     = clamp_ratio(s1_out.zero[1], s1_out.sat[1], d1_quo[1]);
    assign sum    = W2'(gr) + W2'(sr);
    assign d2_num[0] = W2'(sr);
    assign d2_den[0] = sum;

    always_comb begin
        s2_in.sr        = sr;
        s2_in.rg        = clamp_ratio(s1_out.zero[2], s1_out.sat[2], d1_quo[2]);
        s2_in.use_ratio = s1_out.use_ratio;
        s2_in.wdf       = s1_out.wdf;
        s2_in.p_new     = s1_out.p_new;
        s2_in.zero      = (sr == '0);
        s2_in.sat       = (W2'(sr) >= sum);
    end

    logic                   d2_vld;
    logic [0:0][F-1:0]      d2_quo;
    logic [$bits(t_s2)-1:0] d2_side;

    tsp_div_pipe #(
        .LANES (1),
        .W     (W2),
        .Q     (F),
        .SW    ($bits(t_s2))
    ) u_div_comb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d1_vld),
        .i_num   (d2_num),
        .i_den   (d2_den),
        .i_side  (s2_in),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // probability and tie-break ratio select
    t_s2          s2_out;
    logic [F-1:0] p_sel;
    logic         r_c_vld;
    logic [F-1:0] r_c_p, r_c_tr;
    logic [4:0]   r_c_wdf;

    assign s2_out = t_s2'(d2_side);
    assign p_sel  = s2_out.use_ratio ? clamp_ratio(s2_out.zero, s2_out.sat, d2_quo[0])
                                     : s2_out.p_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_p   <= p_sel;
            r_c_tr  <= (p_sel > HALF) ? s2_out.sr : s2_out.rg;
            r_c_wdf <= s2_out.wdf;
        end
    end

    // distance band, tie-break scaling and key packing
    logic [F-1:0]  p_dist;
    logic [F+16:0] band_prod;
    logic [F+19:0] tie_prod;
    logic [F+7:0]  p_ext;
    logic [15:0]   band;
    logic          below;
    t_out          n_out;

    assign below     = (r_c_p < HALF);
    assign p_dist    = below ? (HALF - r_c_p) : (r_c_p - HALF);
    assign band_prod = (F + 17)'(p_dist) * (F + 17)'(100000);
    assign tie_prod  = (F + 20)'(r_c_tr) * (F + 20)'(1000000);
    assign band      = 16'(band_prod >> F);
    assign p_ext     = (F + 8)'(r_c_p);

    always_comb begin
        n_out.probability = 24'((p_ext >> SH_DN) << SH_UP);
        n_out.sort_key    = {band, r_c_wdf, below};
        n_out.tie_break   = 20'(tie_prod >> F);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tsp_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none

module tsp_div_pipe import tsp_pkg::*; #(
    parameter int LANES = 1,
    parameter int W = 28,
    parameter int Q = 24,
    parameter int SW = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [LANES-1:0][W-1:0] i_num,
    input  wire logic [LANES-1:0][W-1:0] i_den,
    input  wire logic [SW-1:0]           i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][Q-1:0]      o_quo,
    output logic [SW-1:0]                o_side
);

    logic [LANES-1:0][W-1:0] r_rem  [Q];
    logic [LANES-1:0][W-1:0] r_den  [Q];
    logic [LANES-1:0][Q-1:0] r_quo  [Q];
    logic [SW-1:0]           r_side [Q];
    logic                    r_vld  [Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [LANES-1:0][W-1:0] p_rem;
        logic [LANES-1:0][W-1:0] p_den;
        logic [LANES-1:0][Q-1:0] p_quo;
        logic [SW-1:0]           p_side;
        logic                    p_vld;
        logic [LANES-1:0][W-1:0] n_rem;
        logic [LANES-1:0][Q-1:0] n_quo;

        // previous stage or the input
        if (k == 0) begin : g_first
            assign p_rem  = i_num;
            assign p_den  = i_den;
            assign p_quo  = '0;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_den  = r_den[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        // shift, compare and subtract in each lane
        for (genvar j = 0; j < LANES; j++) begin : g_lane
            logic [W:0] sh;
            logic       ge;
            assign sh = {p_rem[j], 1'b0};
            assign ge = (sh >= {1'b0, p_den[j]});
            assign n_rem[j] = ge ? W'(sh - {1'b0, p_den[j]}) : sh[W-1:0];
            assign n_quo[j] = {p_quo[j][Q-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= p_den;
                r_quo[k]  <= n_quo;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[Q-1];
    assign o_quo   = r_quo[Q-1];
    assign o_side  = r_side[Q-1];

endmodule

`default_nettype wire

// ===== rtl/core/tsp_checker.sv =====
// port-level checks for the token spam probability scorer
`default_nettype none

module tsp_checker import tsp_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output item valid after reset");

    // a held output item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("held output item changed");

    // input side stalls only behind a held output item
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // below-half flag agrees with the probability
    a_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.sort_key[0] == (o_data.probability < 24'h800000)))
        else $error("sort key below-half flag mismatch");

    // tie-break stays in millionths
    a_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.tie_break < 20'd1000000))
        else $error("tie-break out of range");

endmodule

bind token_spam_probability tsp_checker u_tsp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_token_spam_probability.sv =====
// self-checking testbench for the token spam probability scorer
`timescale 1ns / 100ps

module tb_token_spam_probability;
    import tsp_pkg::*;

    localparam longint unsigned Q_ONE = 64'd1 << 24;
    localparam longint unsigned Q_MIN = Q_ONE / 1000000;
    localparam longint unsigned Q_MAX = (Q_ONE * 999999) / 1000000;
    localparam longint unsigned Q_ZERO = Q_ONE / 10000000;
    localparam longint unsigned Q_HALF = Q_ONE >> 1;
    localparam int PIPE_DEPTH = 51;
    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    // scorer settings as the predictor sees them
    logic [3:0] bias_q;
    logic [7:0] min_count_q;
    logic [23:0] new_score_q;

    t_out score_queue[$];
    int mismatch_count = 0;
    int stall_left = 0;
    bit idle_enable = 1'b1;
    bit failed = 1'b0;

    token_spam_probability dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // clamped ratio in Q0.24
    function automatic longint unsigned hit_ratio(longint unsigned c, longint unsigned t);
        longint unsigned q;
        if (c == 0) return Q_ZERO;
        if (c >= t) return Q_MAX;
        q = (c << 24) / t;
        if (q < Q_MIN) q = Q_MIN;
        if (q > Q_MAX) q = Q_MAX;
        return q;
    endfunction

    // expected score of one token
    function automatic t_out score_token(t_in tok);
        longint unsigned biased, p, gr, sr, half_dist, band, wdf, key, tie_r;
        t_out r;
        biased = longint'(tok.good_hits) * bias_q;
        if (biased + tok.spam_hits >= min_count_q) begin
            gr = hit_ratio(biased, tok.good_messages);
            sr = hit_ratio(tok.spam_hits, tok.spam_messages);
            p = hit_ratio(sr, gr + sr);
        end else begin
            p = new_score_q;
        end
        half_dist = (p >= Q_HALF) ? p - Q_HALF : Q_HALF - p;
        band = (half_dist * 100000) >> 24;
        wdf = tok.occurrences / 3;
        if (wdf > 20) wdf = 20;
        key = (band << 6) | ((wdf & 'h1f) << 1);
        if (p < Q_HALF) key |= 1;
        if (p > Q_HALF) tie_r = hit_ratio(tok.spam_hits, tok.spam_messages);
        else tie_r = hit_ratio(tok.good_hits, tok.good_messages);
        r.probability = p[23:0];
        r.sort_key = key[21:0];
        r.tie_break = 20'((tie_r * 1000000) >> 24);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GOOD_BIAS: bias_q = val[3:0];
            CFG_MIN_WORD_COUNT: min_count_q = val[7:0];
            CFG_NEW_WORD_SCORE: new_score_q = val;
            default: ;
        endcase
    endtask

    task automatic set_scoring(logic [3:0] b, logic [7:0] m, logic [23:0] s);
        write_reg(CFG_GOOD_BIAS, 24'(b));
        write_reg(CFG_MIN_WORD_COUNT, 24'(m));
        write_reg(CFG_NEW_WORD_SCORE, s);
    endtask

    // send one token, idling at random first
    task automatic send_token(t_in tok);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= tok;
        score_queue.push_back(score_token(tok));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (score_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    function automatic t_in rand_token(bit small_counts);
        t_in t;
        if (small_counts) begin
            t.good_hits = 24'($urandom_range(0, 40));
            t.spam_hits = 24'($urandom_range(0, 40));
            t.good_messages = 24'($urandom_range(0, 60));
            t.spam_messages = 24'($urandom_range(0, 60));
        end else begin
            t.good_hits = 24'($urandom);
            t.spam_hits = 24'($urandom);
            t.good_messages = 24'($urandom);
            t.spam_messages = 24'($urandom);
        end
        t.occurrences = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 70));
        return t;
    endfunction

    function automatic t_in mk(int unsigned g, int unsigned s, int unsigned o,
                               int unsigned gm, int unsigned sm);
        t_in t;
        t.good_hits = 24'(g); t.spam_hits = 24'(s); t.occurrences = 16'(o);
        t.good_messages = 24'(gm); t.spam_messages = 24'(sm);
        return t;
    endfunction

    // extremes and special cases at reset settings
    task automatic test_directed();
        send_token(mk(0, 0, 1, 0, 0));
        send_token(mk(1, 1, 3, 100, 100));
        send_token(mk(0, 50, 60, 100, 100));
        send_token(mk(50, 0, 65535, 100, 100));
        send_token(mk(10, 10, 0, 0, 0));
        send_token(mk(10, 10, 2, 5, 1000));
        send_token(mk(24'hffffff, 24'hffffff, 16'hffff, 24'hffffff, 24'hffffff));
        send_token(mk(1, 24'hffffff, 62, 24'hffffff, 24'hffffff));
        send_token(mk(24'hffffff, 1, 63, 24'hffffff, 24'hffffff));
        send_token(mk(1, 1, 9, 24'hffffff, 24'hffffff));
        send_token(mk(3, 6, 30, 12, 12));
        send_token(mk(2, 0, 4, 0, 0));
        send_token(mk(24'haaaaaa, 24'h555555, 16'haaaa, 24'h555555, 24'haaaaaa));
        send_token(mk(24'h555555, 24'haaaaaa, 16'h5555, 24'haaaaaa, 24'h555555));
        drain();
    endtask

    // zero bias, extreme thresholds and new-word scores
    task automatic test_register_extremes();
        set_scoring(4'd0, 8'd255, 24'd0);
        send_token(mk(100, 254, 7, 10, 10));
        send_token(mk(100, 255, 7, 10, 1000));
        drain();
        set_scoring(4'd15, 8'd0, 24'hffffff);
        send_token(mk(0, 0, 1, 0, 0));
        send_token(mk(24'hffffff, 0, 1, 24'hffffff, 10));
        drain();
        set_scoring(4'd1, 8'd200, 24'h800000);
        send_token(mk(0, 0, 30, 0, 0));
        drain();
        write_reg(CFG_UNUSED_IDX, 24'h123456);
        send_token(mk(5, 5, 5, 50, 50));
        drain();
    endtask

    // random tokens at the current settings
    task automatic test_random(int n, bit with_idle);
        idle_enable = with_idle;
        for (int i = 0; i < n; i++) send_token(rand_token($urandom_range(0, 2) != 0));
        drain();
    endtask

    // result checker and output stall bursts
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (score_queue.size() == 0) begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected item %h", o_data);
            end else begin
                want = score_queue.pop_front();
                if (want !== o_data) begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch prob %h/%h key %h/%h tie %h/%h",
                            want.probability, o_data.probability, want.sort_key,
                            o_data.sort_key, want.tie_break, o_data.tie_break);
                end
            end
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (!i_ready) begin
            i_ready <= 1'b1;
        end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            i_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        bias_q = 4'd2;
        min_count_q = 8'd5;
        new_score_q = 24'd6710886;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        set_scoring(4'd2, 8'd5, 24'd6710886);
        test_random(500, 1'b1);
        set_scoring(4'd1, 8'd0, 24'd1);
        test_random(400, 1'b1);
        set_scoring(4'd15, 8'd255, 24'hfffffe);
        test_random(400, 1'b1);
        set_scoring(4'd7, 8'd20, 24'h400000);
        test_random(500, 1'b0);
        if (!failed && score_queue.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/tsp_pkg.sv
rtl/core/tsp_div_pipe.sv
rtl/core/token_spam_probability.sv
rtl/core/tsp_checker.sv
tb/sv/tb_token_spam_probability.sv
